// ===== sv/mdln_pkg.sv =====
// Package for the multi delay line network core.
// Holds field widths, opcodes, the sequencer state type and memory word layouts.
// No dependencies.
package mdln_pkg;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 10;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int SLOT_W  = 10;
	localparam int FIRST_W = 10;
	localparam int FAN_W   = 11;
	localparam int VAL_W   = 16;
	localparam int ACT_W   = 11;
	localparam int OFF_W   = 13;
	localparam int ADDR_W  = 32;
	localparam int END_W   = 12;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_LINE = 3'd0,
		OP_LOAD_NODE = 3'd1,
		OP_PUSH      = 3'd2,
		OP_TICK      = 3'd3,
		OP_READ      = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PUSH_SET,
		ST_PUSH,
		ST_TICK_A,
		ST_TICK_B,
		ST_SLOT_CAP,
		ST_RESP
	} eng_state_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic [SLOT_W-1:0]  dest;
	} line_t;

	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [FAN_W-1:0]   count;
	} node_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] read_value;
		logic             status;
	} eng_res_t;

endpackage

// ===== sv/mdln_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used by mdln_engine for every state store. No package dependency.
module mdln_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/mdln_engine.sv =====
// Sequencer and state memories of the delay line network: clearing pass,
// descriptor loads, push fan-out and the two-pass tick walk.
// Depends on mdln_pkg and mdln_ram.
module mdln_engine #(
	parameter int MAX_LINES  = 1024,
	parameter int BUF_DEPTH  = 4096,
	parameter int MAX_NODES  = 256,
	parameter int VALUE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mdln_pkg::OP_W-1:0]    op,
	input  logic [mdln_pkg::IDX_W-1:0]   index,
	input  logic [mdln_pkg::START_W-1:0] buf_start,
	input  logic [mdln_pkg::LEN_W-1:0]   delay_length,
	input  logic [mdln_pkg::SLOT_W-1:0]  out_slot,
	input  logic [mdln_pkg::FIRST_W-1:0] first_line,
	input  logic [mdln_pkg::FAN_W-1:0]   fanout,
	input  logic [mdln_pkg::VAL_W-1:0]   value,
	input  logic [mdln_pkg::ACT_W-1:0]   active_lines,
	input  logic                       out_free,
	output mdln_pkg::eng_res_t         res
);

	localparam int LAW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int BAW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int NAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int KW   = (LAW + 1 > mdln_pkg::END_W) ? LAW + 1 : mdln_pkg::END_W;
	localparam int CLR_A = (BUF_DEPTH > MAX_LINES) ? BUF_DEPTH : MAX_LINES;
	localparam int CLR_N = (CLR_A > MAX_NODES) ? CLR_A : MAX_NODES;
	localparam int CLW  = $clog2(CLR_N) + 1;
	localparam int VW   = mdln_pkg::VAL_W;
	localparam int LNW  = $bits(mdln_pkg::line_t);
	localparam int NDW  = $bits(mdln_pkg::node_t);
	localparam logic [VW-1:0] VMASK = (VALUE_BITS >= VW) ? {VW{1'b1}} :
		VW'((33'(1) << VALUE_BITS) - 33'(1));

	mdln_pkg::eng_state_t state_q, state_d;

	logic [mdln_pkg::OP_W-1:0]    op_q;
	logic [mdln_pkg::IDX_W-1:0]   idx_q;
	logic [mdln_pkg::START_W-1:0] bstart_q;
	logic [mdln_pkg::LEN_W-1:0]   dlen_q;
	logic [mdln_pkg::SLOT_W-1:0]  oslot_q;
	logic [mdln_pkg::FIRST_W-1:0] first_q;
	logic [mdln_pkg::FAN_W-1:0]   fan_q;
	logic [VW-1:0]                val_q;

	logic [KW-1:0]               k_q;
	logic [mdln_pkg::END_W-1:0]  end_q;
	logic [CLW-1:0]              clr_q;
	logic                        v_s1, v_s2;
	logic [LAW-1:0]              k_s1;
	logic [mdln_pkg::SLOT_W-1:0] dest_s2;
	logic                        inb_s2;
	logic [VW-1:0]               res_val_q;
	logic                        res_st_q;

	// Memory ports.
	logic line_we, off_we, in_we, store_we, slot_we, node_we;
	logic [LAW-1:0] line_waddr, off_waddr, in_waddr, slot_waddr;
	logic [LAW-1:0] line_raddr, slot_raddr;
	logic [BAW-1:0] store_waddr, store_raddr;
	logic [NAW-1:0] node_waddr, node_raddr;
	logic [LNW-1:0] line_wdata, line_rdata;
	logic [NDW-1:0] node_wdata, node_rdata;
	logic [mdln_pkg::OFF_W-1:0] off_wdata, off_rdata;
	logic [VW-1:0] in_wdata, in_rdata, store_wdata, store_rdata, slot_wdata, slot_rdata;

	mdln_pkg::line_t ln;
	mdln_pkg::node_t nd;
	logic [mdln_pkg::ADDR_W-1:0] idx32, clr32, k32, a32;
	logic line_ok, node_ok, push_ok, tick_ok, read_ok, exec_status;
	logic k_lt_n, push_go, a_in, clr_last;
	logic [mdln_pkg::OFF_W:0] nx;
	logic [mdln_pkg::OFF_W-1:0] off_new;

	assign ln    = mdln_pkg::line_t'(line_rdata);
	assign nd    = mdln_pkg::node_t'(node_rdata);
	assign idx32 = mdln_pkg::ADDR_W'(idx_q);
	assign clr32 = mdln_pkg::ADDR_W'(clr_q);
	assign k32   = mdln_pkg::ADDR_W'(k_q);

	assign line_ok = (idx32 < MAX_LINES) && (mdln_pkg::ADDR_W'(oslot_q) < MAX_LINES) &&
		(dlen_q != '0) &&
		(mdln_pkg::ADDR_W'(bstart_q) + mdln_pkg::ADDR_W'(dlen_q) <= BUF_DEPTH);
	assign node_ok = (idx32 < MAX_NODES) &&
		(mdln_pkg::ADDR_W'(first_q) + mdln_pkg::ADDR_W'(fan_q) <= MAX_LINES);
	assign push_ok = idx32 < MAX_NODES;
	assign tick_ok = mdln_pkg::ADDR_W'(active_lines) <= MAX_LINES;
	assign read_ok = idx32 < MAX_LINES;

	always_comb begin
		case (op_q)
			mdln_pkg::OP_LOAD_LINE: exec_status = !line_ok;
			mdln_pkg::OP_LOAD_NODE: exec_status = !node_ok;
			mdln_pkg::OP_PUSH:      exec_status = !push_ok;
			mdln_pkg::OP_TICK:      exec_status = !tick_ok;
			mdln_pkg::OP_READ:      exec_status = !read_ok;
			default:                exec_status = 1'b1;
		endcase
	end

	assign k_lt_n   = k32 < mdln_pkg::ADDR_W'(active_lines);
	assign push_go  = (k32 < mdln_pkg::ADDR_W'(end_q)) && (k32 < MAX_LINES);
	assign clr_last = clr32 == CLR_N - 1;

	// Head address and next offset of the line read in the previous cycle.
	assign a32     = mdln_pkg::ADDR_W'(ln.start) + mdln_pkg::ADDR_W'(off_rdata);
	assign a_in    = a32 < BUF_DEPTH;
	assign nx      = (mdln_pkg::OFF_W + 1)'(off_rdata) + 1'b1;
	assign off_new = (nx >= (mdln_pkg::OFF_W + 1)'(ln.len)) ? '0 : nx[mdln_pkg::OFF_W-1:0];

	assign in_ready = state_q == mdln_pkg::ST_IDLE;
	assign res.valid      = state_q == mdln_pkg::ST_RESP;
	assign res.read_value = res_val_q;
	assign res.status     = res_st_q;

	always_comb begin
		state_d     = state_q;
		line_we     = 1'b0;
		off_we      = 1'b0;
		in_we       = 1'b0;
		store_we    = 1'b0;
		slot_we     = 1'b0;
		node_we     = 1'b0;
		line_waddr  = idx32[LAW-1:0];
		line_wdata  = {bstart_q, dlen_q, oslot_q};
		line_raddr  = k_q[LAW-1:0];
		off_waddr   = k_s1;
		off_wdata   = off_new;
		in_waddr    = k_q[LAW-1:0];
		in_wdata    = val_q;
		store_waddr = a32[BAW-1:0];
		store_wdata = in_rdata;
		store_raddr = a32[BAW-1:0];
		slot_waddr  = mdln_pkg::ADDR_W'(dest_s2) >= MAX_LINES ? '0 :
			LAW'(mdln_pkg::ADDR_W'(dest_s2));
		slot_wdata  = inb_s2 ? store_rdata : '0;
		slot_raddr  = idx32[LAW-1:0];
		node_waddr  = idx32[NAW-1:0];
		node_wdata  = {first_q, fan_q};
		node_raddr  = idx32[NAW-1:0];
		case (state_q)
			mdln_pkg::ST_CLEAR: begin
				off_we      = clr32 < MAX_LINES;
				in_we       = clr32 < MAX_LINES;
				slot_we     = clr32 < MAX_LINES;
				store_we    = clr32 < BUF_DEPTH;
				node_we     = clr32 < MAX_NODES;
				off_waddr   = clr32[LAW-1:0];
				in_waddr    = clr32[LAW-1:0];
				slot_waddr  = clr32[LAW-1:0];
				store_waddr = clr32[BAW-1:0];
				node_waddr  = clr32[NAW-1:0];
				off_wdata   = '0;
				in_wdata    = '0;
				slot_wdata  = '0;
				store_wdata = '0;
				node_wdata  = '0;
				if (clr_last) begin
					state_d = mdln_pkg::ST_IDLE;
				end
			end
			mdln_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mdln_pkg::ST_EXEC;
				end
			end
			mdln_pkg::ST_EXEC: begin
				state_d = mdln_pkg::ST_RESP;
				case (op_q)
					mdln_pkg::OP_LOAD_LINE: begin
						line_we   = line_ok;
						off_we    = line_ok;
						off_waddr = idx32[LAW-1:0];
						off_wdata = '0;
					end
					mdln_pkg::OP_LOAD_NODE: begin
						node_we = node_ok;
					end
					mdln_pkg::OP_PUSH: begin
						if (push_ok) begin
							state_d = mdln_pkg::ST_PUSH_SET;
						end
					end
					mdln_pkg::OP_TICK: begin
						if (tick_ok) begin
							state_d = mdln_pkg::ST_TICK_A;
						end
					end
					mdln_pkg::OP_READ: begin
						if (read_ok) begin
							state_d = mdln_pkg::ST_SLOT_CAP;
						end
					end
					default: begin
					end
				endcase
			end
			mdln_pkg::ST_PUSH_SET: begin
				state_d = mdln_pkg::ST_PUSH;
			end
			mdln_pkg::ST_PUSH: begin
				if (push_go) begin
					in_we = 1'b1;
				end else begin
					state_d = mdln_pkg::ST_RESP;
				end
			end
			mdln_pkg::ST_TICK_A: begin
				store_we = v_s1 && a_in;
				off_we   = v_s1;
				if (!k_lt_n && !v_s1) begin
					state_d = mdln_pkg::ST_TICK_B;
				end
			end
			mdln_pkg::ST_TICK_B: begin
				slot_we = v_s2 && (mdln_pkg::ADDR_W'(dest_s2) < MAX_LINES);
				if (!k_lt_n && !v_s1 && !v_s2) begin
					state_d = mdln_pkg::ST_RESP;
				end
			end
			mdln_pkg::ST_SLOT_CAP: begin
				state_d = mdln_pkg::ST_RESP;
			end
			mdln_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = mdln_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdln_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdln_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			end_q     <= '0;
			clr_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			res_val_q <= '0;
			res_st_q  <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (state_q == mdln_pkg::ST_TICK_B);
			case (state_q)
				mdln_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				mdln_pkg::ST_EXEC: begin
					res_st_q  <= exec_status;
					res_val_q <= '0;
					k_q       <= '0;
					v_s1      <= 1'b0;
				end
				mdln_pkg::ST_PUSH_SET: begin
					k_q   <= KW'(nd.first);
					end_q <= mdln_pkg::END_W'(nd.first) + mdln_pkg::END_W'(nd.count);
				end
				mdln_pkg::ST_PUSH: begin
					k_q <= k_q + 1'b1;
				end
				mdln_pkg::ST_TICK_A, mdln_pkg::ST_TICK_B: begin
					if (k_lt_n) begin
						k_q  <= k_q + 1'b1;
						v_s1 <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (state_q == mdln_pkg::ST_TICK_A && !k_lt_n && !v_s1) begin
						k_q <= '0;
					end
				end
				mdln_pkg::ST_SLOT_CAP: begin
					res_val_q <= slot_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdln_pkg::ST_IDLE && in_valid) begin
			op_q     <= op;
			idx_q    <= index;
			bstart_q <= buf_start;
			dlen_q   <= delay_length;
			oslot_q  <= out_slot;
			first_q  <= first_line;
			fan_q    <= fanout;
			val_q    <= value & VMASK;
		end
		k_s1    <= k_q[LAW-1:0];
		dest_s2 <= ln.dest;
		inb_s2  <= a_in;
	end

	mdln_ram #(.DEPTH(MAX_LINES), .WIDTH(LNW)) u_line (
		.clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
		.raddr(line_raddr), .rdata(line_rdata)
	);

	mdln_ram #(.DEPTH(MAX_LINES), .WIDTH(mdln_pkg::OFF_W)) u_off (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
		.raddr(line_raddr), .rdata(off_rdata)
	);

	mdln_ram #(.DEPTH(MAX_LINES), .WIDTH(VW)) u_in (
		.clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
		.raddr(line_raddr), .rdata(in_rdata)
	);

	mdln_ram #(.DEPTH(BUF_DEPTH), .WIDTH(VW)) u_store (
		.clk(clk), .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
		.raddr(store_raddr), .rdata(store_rdata)
	);

	mdln_ram #(.DEPTH(MAX_LINES), .WIDTH(VW)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	mdln_ram #(.DEPTH(MAX_NODES), .WIDTH(NDW)) u_node (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

endmodule

// ===== sv/multi_delay_line_network_core.sv =====
// Top level of the multi delay line network: configuration register, result
// register and the sequencer with its memories. Depends on mdln_pkg and mdln_engine.
//
// Usage. The input channel (in_valid/in_ready) carries one transaction per item:
// load a line descriptor, load a node's fan-out range, push a node value, tick,
// or read an output slot. Every item yields exactly one result transaction on
// the output channel (out_valid/out_ready) with read_value and status.
// The configuration channel (cfg_valid/cfg_ready) writes active_lines, the number
// of lines walked on each tick; it is always ready and should only be written
// while no item is in flight.
// A tick runs two passes of one line per cycle: the first writes every pending input
// into the shared buffer and advances the offsets, the second reads each new head
// and writes it to the line's output slot. Only one item is worked on at a time.
// Reset. After arst_n is released a clearing pass zeroes the buffer, offsets,
// pending inputs, output slots and node table, one entry per cycle; no item is
// accepted until it ends. Configuration writes are taken throughout.
// Stalls. A finished result sits in the output register; the next item may be
// accepted meanwhile, and its own result waits until the register is free.
module multi_delay_line_network_core #(
	parameter int MAX_LINES  = 1024,
	parameter int BUF_DEPTH  = 4096,
	parameter int MAX_NODES  = 256,
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mdln_pkg::ACT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mdln_pkg::OP_W-1:0]     op,
	input  logic [mdln_pkg::IDX_W-1:0]    index,
	input  logic [mdln_pkg::START_W-1:0]  buf_start,
	input  logic [mdln_pkg::LEN_W-1:0]    delay_length,
	input  logic [mdln_pkg::SLOT_W-1:0]   out_slot,
	input  logic [mdln_pkg::FIRST_W-1:0]  first_line,
	input  logic [mdln_pkg::FAN_W-1:0]    fanout,
	input  logic [mdln_pkg::VAL_W-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mdln_pkg::VAL_W-1:0]    read_value,
	output logic                          status
);

	logic [mdln_pkg::ACT_W-1:0] active_lines_q;
	logic                       out_valid_q;
	logic [mdln_pkg::VAL_W-1:0] read_value_q;
	logic                       status_q;
	logic                       out_free;
	mdln_pkg::eng_res_t         res;

	// The configuration register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_lines_q <= '0;
		end else if (cfg_valid) begin
			active_lines_q <= cfg_data;
		end
	end

	// The output register is free when empty or when its result leaves this cycle.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			read_value_q <= res.read_value;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	mdln_engine #(
		.MAX_LINES(MAX_LINES),
		.BUF_DEPTH(BUF_DEPTH),
		.MAX_NODES(MAX_NODES),
		.VALUE_BITS(VALUE_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.index(index),
		.buf_start(buf_start),
		.delay_length(delay_length),
		.out_slot(out_slot),
		.first_line(first_line),
		.fanout(fanout),
		.value(value),
		.active_lines(active_lines_q),
		.out_free(out_free),
		.res(res)
	);

endmodule

// ===== tb/multi_delay_line_network_core_tb.sv =====
// Self-checking testbench for multi_delay_line_network_core: directed and random items
// checked against an in-bench delay line predictor. Depends on mdln_pkg and the core RTL.
module multi_delay_line_network_core_tb;

	localparam int N_LINES = 1024;
	localparam int N_DEPTH = 4096;
	localparam int N_NODES = 256;

	typedef struct {
		logic [mdln_pkg::OP_W-1:0]    op;
		logic [mdln_pkg::IDX_W-1:0]   index;
		logic [mdln_pkg::START_W-1:0] buf_start;
		logic [mdln_pkg::LEN_W-1:0]   delay_length;
		logic [mdln_pkg::SLOT_W-1:0]  out_slot;
		logic [mdln_pkg::FIRST_W-1:0] first_line;
		logic [mdln_pkg::FAN_W-1:0]   fanout;
		logic [mdln_pkg::VAL_W-1:0]   value;
		bit                           is_cfg;
		logic [mdln_pkg::ACT_W-1:0]   cfg_value;
	} item_t;

	typedef struct {
		logic [mdln_pkg::VAL_W-1:0] read_value;
		logic                       status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mdln_pkg::ACT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [mdln_pkg::OP_W-1:0] op = '0;
	logic [mdln_pkg::IDX_W-1:0] index = '0;
	logic [mdln_pkg::START_W-1:0] buf_start = '0;
	logic [mdln_pkg::LEN_W-1:0] delay_length = '0;
	logic [mdln_pkg::SLOT_W-1:0] out_slot = '0;
	logic [mdln_pkg::FIRST_W-1:0] first_line = '0;
	logic [mdln_pkg::FAN_W-1:0] fanout = '0;
	logic [mdln_pkg::VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [mdln_pkg::VAL_W-1:0] read_value;
	logic status;

	multi_delay_line_network_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .index(index), .buf_start(buf_start), .delay_length(delay_length),
		.out_slot(out_slot), .first_line(first_line), .fanout(fanout), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .status(status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: a shadow of every memory of the block.
	logic [mdln_pkg::VAL_W-1:0]   pm_store [N_DEPTH];
	logic [mdln_pkg::START_W-1:0] pm_start [N_LINES];
	logic [mdln_pkg::LEN_W-1:0]   pm_len   [N_LINES];
	logic [mdln_pkg::OFF_W-1:0]   pm_off   [N_LINES];
	logic [mdln_pkg::SLOT_W-1:0]  pm_dest  [N_LINES];
	logic [mdln_pkg::VAL_W-1:0]   pm_input [N_LINES];
	logic [mdln_pkg::VAL_W-1:0]   pm_slot  [N_LINES];
	logic [mdln_pkg::FIRST_W-1:0] pm_first [N_NODES];
	logic [mdln_pkg::FAN_W-1:0]   pm_count [N_NODES];
	logic [mdln_pkg::ACT_W-1:0]   pm_active;

	// Lines and nodes loaded so far, so that ticks only walk loaded lines
	// and pushes only go to loaded nodes.
	bit line_loaded [N_LINES];
	bit node_loaded [N_NODES];

	item_t pending_items[$];
	answer_t expected_answers[$];
	int error_count = 0;
	bit idling_on = 1;
	bit long_hold = 0;

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	function automatic void predictor_reset();
		for (int k = 0; k < N_DEPTH; k++) pm_store[k] = '0;
		for (int k = 0; k < N_LINES; k++) begin
			pm_start[k] = '0; pm_len[k] = '0; pm_off[k] = '0; pm_dest[k] = '0;
			pm_input[k] = '0; pm_slot[k] = '0;
		end
		for (int k = 0; k < N_NODES; k++) begin
			pm_first[k] = '0; pm_count[k] = '0;
		end
		pm_active = '0;
	endfunction

	// Computes the one answer of an item and updates the shadow state.
	function automatic answer_t predict_answer(input item_t it);
		answer_t a;
		int unsigned addr;
		int unsigned nx;
		a.read_value = '0;
		a.status = 1'b0;
		case (it.op)
			mdln_pkg::OP_LOAD_LINE: begin
				if (it.delay_length == 0 || it.buf_start + it.delay_length > N_DEPTH) begin
					a.status = 1'b1;
				end else begin
					pm_start[it.index] = it.buf_start;
					pm_len[it.index] = it.delay_length;
					pm_dest[it.index] = it.out_slot;
					pm_off[it.index] = '0;
				end
			end
			mdln_pkg::OP_LOAD_NODE: begin
				if (it.index >= N_NODES || it.first_line + it.fanout > N_LINES) begin
					a.status = 1'b1;
				end else begin
					pm_first[it.index] = it.first_line;
					pm_count[it.index] = it.fanout;
				end
			end
			mdln_pkg::OP_PUSH: begin
				if (it.index >= N_NODES) begin
					a.status = 1'b1;
				end else begin
					for (int k = pm_first[it.index];
					     k < pm_first[it.index] + pm_count[it.index] && k < N_LINES; k++)
						pm_input[k] = it.value;
				end
			end
			mdln_pkg::OP_TICK: begin
				if (pm_active > N_LINES) begin
					a.status = 1'b1;
				end else begin
					for (int k = 0; k < pm_active; k++) begin
						addr = pm_start[k] + pm_off[k];
						if (addr < N_DEPTH) pm_store[addr] = pm_input[k];
					end
					for (int k = 0; k < pm_active; k++) begin
						nx = pm_off[k] + 1;
						pm_off[k] = (nx >= pm_len[k]) ? '0 : mdln_pkg::OFF_W'(nx);
					end
					for (int k = 0; k < pm_active; k++) begin
						addr = pm_start[k] + pm_off[k];
						pm_slot[pm_dest[k]] = (addr < N_DEPTH) ? pm_store[addr] : '0;
					end
				end
			end
			mdln_pkg::OP_READ: a.read_value = pm_slot[it.index];
			default: a.status = 1'b1;
		endcase
		return a;
	endfunction

	function automatic item_t blank_item(input logic [mdln_pkg::OP_W-1:0] o);
		item_t it;
		it.op = o;
		it.index = mdln_pkg::IDX_W'($urandom);
		it.buf_start = mdln_pkg::START_W'($urandom);
		it.delay_length = mdln_pkg::LEN_W'($urandom);
		it.out_slot = mdln_pkg::SLOT_W'($urandom);
		it.first_line = mdln_pkg::FIRST_W'($urandom);
		it.fanout = mdln_pkg::FAN_W'($urandom);
		it.value = mdln_pkg::VAL_W'($urandom);
		it.is_cfg = 0;
		it.cfg_value = '0;
		return it;
	endfunction

	function automatic void add_line(input int ln, input int st, input int len, input int sl);
		item_t it;
		it = blank_item(mdln_pkg::OP_LOAD_LINE);
		it.index = mdln_pkg::IDX_W'(ln);
		it.buf_start = mdln_pkg::START_W'(st);
		it.delay_length = mdln_pkg::LEN_W'(len);
		it.out_slot = mdln_pkg::SLOT_W'(sl);
		pending_items.push_back(it);
		if (len != 0 && st + len <= N_DEPTH) line_loaded[ln] = 1;
	endfunction

	function automatic void add_node(input int nd, input int fl, input int fo);
		item_t it;
		it = blank_item(mdln_pkg::OP_LOAD_NODE);
		it.index = mdln_pkg::IDX_W'(nd);
		it.first_line = mdln_pkg::FIRST_W'(fl);
		it.fanout = mdln_pkg::FAN_W'(fo);
		pending_items.push_back(it);
		if (nd < N_NODES && fl + fo <= N_LINES) node_loaded[nd] = 1;
	endfunction

	function automatic void add_simple(input int o, input int idx, input int v);
		item_t it;
		it = blank_item(mdln_pkg::OP_W'(o));
		it.index = mdln_pkg::IDX_W'(idx);
		it.value = mdln_pkg::VAL_W'(v);
		pending_items.push_back(it);
	endfunction

	function automatic void add_config(input int act);
		item_t it;
		it = blank_item(mdln_pkg::OP_TICK);
		it.is_cfg = 1;
		it.cfg_value = mdln_pkg::ACT_W'(act);
		pending_items.push_back(it);
	endfunction

	// Highest loaded-prefix: ticks may only walk lines that have been loaded.
	function automatic int loaded_prefix();
		int n;
		n = 0;
		while (n < N_LINES && line_loaded[n]) n++;
		return n;
	endfunction

	// Driver: sends transactions from the pending queue. A configuration entry
	// waits until every earlier result has been received before it is written.
	int gap_left = 0;
	always @(posedge clk) begin
		item_t head;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				head = pending_items.pop_front();
				expected_answers.push_back(predict_answer(head));
			end
			if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
				if (cfg_valid || pending_items.size() == 0) begin
					cfg_valid <= 1'b0;
					in_valid <= 1'b0;
				end else if (pending_items[0].is_cfg) begin
					in_valid <= 1'b0;
					if (expected_answers.size() == 0) begin
						head = pending_items.pop_front();
						pm_active = head.cfg_value;
						cfg_data <= head.cfg_value;
						cfg_valid <= 1'b1;
					end
				end else if (idling_on && gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (idling_on && $urandom_range(0, 9) == 0) begin
					gap_left <= $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					op <= pending_items[0].op;
					index <= pending_items[0].index;
					buf_start <= pending_items[0].buf_start;
					delay_length <= pending_items[0].delay_length;
					out_slot <= pending_items[0].out_slot;
					first_line <= pending_items[0].first_line;
					fanout <= pending_items[0].fanout;
					value <= pending_items[0].value;
				end
			end
		end
	end

	// The item at the head of the queue is consumed only on acceptance, so the
	// payload driven above always matches pending_items[0] while valid is high.

	// Monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = expected_answers.pop_front();
				if (read_value !== e.read_value)
					report_mismatch($sformatf("read_value %h, expected %h", read_value,
						e.read_value));
				if (status !== e.status)
					report_mismatch($sformatf("status %b, expected %b", status, e.status));
			end
		end
	end

	// Receiver stalls: random bursts, a long hold-off when asked, none late on.
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold) begin
			out_ready <= 1'b0;
		end else if (!idling_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	initial begin
		wait (arst_n);
		wait (pending_items.size() < 400);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("multi_delay_line_network_core_tb: errors");
		$finish;
	end

	initial begin
		int r;
		int ln;
		int len;
		int act;
		predictor_reset();
		for (int k = 0; k < N_LINES; k++) line_loaded[k] = 0;
		for (int k = 0; k < N_NODES; k++) node_loaded[k] = 0;

		// Directed part: field extremes, every op and every rejected case.
		add_simple(mdln_pkg::OP_READ, 0, 0);            // slot after reset reads zero
		add_line(0, 0, 1, 0);                 // shortest line
		add_line(1, 0, 4096, 1023);           // longest line, top slot
		add_line(2, 4095, 1, 5);              // last buffer word
		add_line(3, 4095, 2, 5);              // runs past the buffer: ignored
		add_line(3, 100, 0, 5);               // zero length: ignored
		add_line(3, 4000, 96, 1);             // exact fit
		add_line(4, 4000, 8, 7);              // overlaps line 3
		add_node(0, 0, 5);
		add_node(255, 1023, 1);               // highest node, last line
		add_node(256, 0, 1);                  // node out of range
		add_node(1, 1, 1024);                 // range past the last line
		add_node(2, 0, 0);                    // empty fan-out
		add_simple(mdln_pkg::OP_PUSH, 0, 16'hFFFF);
		add_simple(mdln_pkg::OP_PUSH, 2, 16'h1234);
		add_simple(mdln_pkg::OP_PUSH, 1023, 16'h0);     // node out of range
		add_config(5);
		add_simple(mdln_pkg::OP_TICK, 0, 0);
		add_simple(mdln_pkg::OP_READ, 0, 0);
		add_simple(mdln_pkg::OP_READ, 1023, 0);
		add_simple(mdln_pkg::OP_READ, 5, 0);
		add_simple(5, 0, 0);
		add_simple(7, 1023, 16'hFFFF);
		add_config(0);
		add_simple(mdln_pkg::OP_TICK, 0, 0);            // no active lines
		add_config(1025);
		add_simple(mdln_pkg::OP_TICK, 0, 0);            // beyond the line count: ignored
		add_config(2047);
		add_simple(mdln_pkg::OP_TICK, 0, 0);

		// Random part, in phases with different active line counts.
		while (pending_items.size() < 580) begin
			act = loaded_prefix();
			case ($urandom_range(0, 3))
				0: act = (act < 8) ? act : $urandom_range(1, 8);
				1: act = (act < 40) ? act : $urandom_range(8, 40);
				default: act = (act < 12) ? act : $urandom_range(0, 12);
			endcase
			add_config(act);
			for (int j = 0; j < 60 && pending_items.size() < 580; j++) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					ln = $urandom_range(0, 47);
					if ($urandom_range(0, 9) == 0) ln = $urandom_range(0, 1023);
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
						: $urandom_range(1, 12);
					if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 8191);
					add_line(ln, $urandom_range(0, 4095 - (len > 4095 ? 4095 : len - 1)),
						len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(0, 47));
					if ($urandom_range(0, 9) == 0) begin
						// Random start that may overflow the buffer.
						add_line(ln, $urandom_range(0, 4095), $urandom_range(0, 8191),
							$urandom_range(0, 1023));
					end
				end else if (r < 25) begin
					if ($urandom_range(0, 9) == 0)
						add_node($urandom_range(0, 1023), $urandom_range(0, 1023),
							$urandom_range(0, 2047));
					else begin
						ln = $urandom_range(0, 40);
						while (ln > 0 && !line_loaded[ln]) ln--;
						if (line_loaded[ln])
							add_node($urandom_range(0, 15), ln, $urandom_range(0, 8));
					end
				end else if (r < 45) begin
					ln = $urandom_range(0, 15);
					if ($urandom_range(0, 14) == 0) ln = $urandom_range(256, 1023);
					// Pushes go only to loaded nodes or to nodes out of range.
					if (ln >= N_NODES || node_loaded[ln])
						add_simple(mdln_pkg::OP_PUSH, ln, $urandom_range(0, 65535));
				end else if (r < 70) begin
					add_simple(mdln_pkg::OP_TICK, 0, 0);
				end else if (r < 95) begin
					add_simple(mdln_pkg::OP_READ, ($urandom_range(0, 9) == 0) ?
						$urandom_range(0, 1023) : $urandom_range(0, 47), 0);
				end else begin
					add_simple($urandom_range(5, 7), $urandom_range(0, 1023),
						$urandom_range(0, 65535));
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() < 60);
		idling_on <= 1'b0;
		wait (pending_items.size() == 0 && !in_valid && !cfg_valid);
		wait (expected_answers.size() == 0);
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("multi_delay_line_network_core_tb: clean");
		end else begin
			$display("multi_delay_line_network_core_tb: errors");
		end
		$finish;
	end

endmodule
